// ===== design/ptc_pkg.sv =====
// Shared constants and types of the point-triangle classifier.
package ptc_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 24;
    localparam int LIMIT_BITS = 24;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic
    {
        REG_VERTEX_SNAP,
        REG_EDGE_SNAP
    } reg_index_t;

    typedef enum logic [1:0]
    {
        REL_VERTEX,
        REL_EDGE,
        REL_INTERIOR,
        REL_EXTERIOR
    } relation_t;

    localparam logic [1:0] ELEM_FIRST = 2'd0;
    localparam logic [1:0] ELEM_SECOND = 2'd1;
    localparam logic [1:0] ELEM_THIRD = 2'd2;

endpackage

// ===== design/point_triangle_classify.sv =====
// Top level of the point-triangle classifier with its configuration registers.
//
// The block takes one query transaction per clock and never asserts busy. Each result
// appears on result_valid, relation_kind and element_index for exactly one cycle; the
// receiver cannot stall and must take every result in the cycle it is shown. The
// nine-stage pipeline (input register, differences, products, sums, a two-stage wide
// multiplier, final subtractions, compares and the priority select) produces each
// result. The snap limits are squared in a register and first used after the sums
// stage, so a configuration write already applies to transactions accepted before it
// and still in flight; write the limits only while no transaction is in flight.
module point_triangle_classify #(
    parameter int COORD_BITS = ptc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS = ptc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [ptc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [ptc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        point_x,
    input  logic signed [COORD_BITS-1:0]        point_y,
    input  logic signed [COORD_BITS-1:0]        point_z,
    input  logic signed [COORD_BITS-1:0]        corner_a_x,
    input  logic signed [COORD_BITS-1:0]        corner_a_y,
    input  logic signed [COORD_BITS-1:0]        corner_a_z,
    input  logic signed [COORD_BITS-1:0]        corner_b_x,
    input  logic signed [COORD_BITS-1:0]        corner_b_y,
    input  logic signed [COORD_BITS-1:0]        corner_b_z,
    input  logic signed [COORD_BITS-1:0]        corner_c_x,
    input  logic signed [COORD_BITS-1:0]        corner_c_y,
    input  logic signed [COORD_BITS-1:0]        corner_c_z,
    output logic                                result_valid,
    output logic [1:0]                          relation_kind,
    output logic [1:0]                          element_index
);

    localparam int LB = ptc_pkg::LIMIT_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;
    localparam int CW = PW + 1;
    localparam int XSW = 2 * CW;
    localparam int XW = XSW + 2;
    localparam int L2W = 2 * LB + 1;
    localparam int LEW = L2W + SW;
    localparam int VCW = (SW > L2W) ? SW : L2W;
    localparam int EW = (XW > LEW) ? XW : LEW;
    localparam int MW = 2 * SW;
    localparam int DNW = MW + 1;
    localparam int NSW = MW + 2;
    localparam int STAGES = 9;
    localparam logic [LB-1:0] SNAP_RESET =
        LB'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);

    logic [LB-1:0]      vertex_snap_reg;
    logic [LB-1:0]      edge_snap_reg;
    logic [2*LB-1:0]    vl2_reg;
    logic [2*LB-1:0]    el2_reg;
    logic               cfg_write;
    ptc_pkg::reg_index_t cfg_index;

    assign pready = 1'b1;
    assign busy = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = ptc_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_snap_reg <= SNAP_RESET;
            edge_snap_reg <= SNAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ptc_pkg::REG_VERTEX_SNAP: vertex_snap_reg <= pwdata[LB-1:0];
                ptc_pkg::REG_EDGE_SNAP:   edge_snap_reg <= pwdata[LB-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            ptc_pkg::REG_VERTEX_SNAP: prdata = ptc_pkg::APB_DATA_BITS'(vertex_snap_reg);
            ptc_pkg::REG_EDGE_SNAP:   prdata = ptc_pkg::APB_DATA_BITS'(edge_snap_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        vl2_reg <= vertex_snap_reg * vertex_snap_reg;
        el2_reg <= edge_snap_reg * edge_snap_reg;
    end

    // Valid bits of the nine stages.
    logic [STAGES-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], start && !busy};
        end
    end

    logic signed [COORD_BITS-1:0] in_p [3];
    logic signed [COORD_BITS-1:0] in_c [3][3];

    assign in_p[0] = point_x;
    assign in_p[1] = point_y;
    assign in_p[2] = point_z;
    assign in_c[0][0] = corner_a_x;
    assign in_c[0][1] = corner_a_y;
    assign in_c[0][2] = corner_a_z;
    assign in_c[1][0] = corner_b_x;
    assign in_c[1][1] = corner_b_y;
    assign in_c[1][2] = corner_b_z;
    assign in_c[2][0] = corner_c_x;
    assign in_c[2][1] = corner_c_y;
    assign in_c[2][2] = corner_c_z;

    logic signed [COORD_BITS-1:0] p_reg [3];
    logic signed [COORD_BITS-1:0] c_reg [3][3];
    logic signed [DW-1:0] vp_reg [3][3];
    logic signed [DW-1:0] e_reg [3][3];
    logic signed [PW-1:0] sqv_reg [3][3];
    logic signed [PW-1:0] sqe_reg [3][3];
    logic signed [PW-1:0] we_reg [3][3];
    logic signed [PW-1:0] qp_reg [3];
    logic signed [PW-1:0] rp_reg [3];
    logic signed [PW-1:0] cxa_reg [3][3];
    logic signed [PW-1:0] cxb_reg [3][3];
    logic signed [SW-1:0] dv_reg [3];
    logic signed [SW-1:0] de_reg [3];
    logic signed [SW-1:0] dwe_reg [3];
    logic signed [SW-1:0] q_reg;
    logic signed [SW-1:0] r_reg;
    logic signed [CW-1:0] cc_reg [3][3];

    // Edges are ordered CA, AB, BC; the point is measured from each edge's start corner.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_reg[k] <= in_p[k];
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i][k] <= in_c[i][k];
                vp_reg[i][k] <= DW'(p_reg[k]) - DW'(c_reg[i][k]);
                e_reg[i][k] <= DW'(c_reg[i][k]) - DW'(c_reg[(i + 2) % 3][k]);
                sqv_reg[i][k] <= vp_reg[i][k] * vp_reg[i][k];
                sqe_reg[i][k] <= e_reg[i][k] * e_reg[i][k];
                we_reg[i][k] <= vp_reg[(i + 2) % 3][k] * e_reg[i][k];
                cxa_reg[i][k] <= e_reg[i][(k + 1) % 3] * vp_reg[(i + 2) % 3][(k + 2) % 3];
                cxb_reg[i][k] <= e_reg[i][(k + 2) % 3] * vp_reg[(i + 2) % 3][(k + 1) % 3];
                cc_reg[i][k] <= CW'(cxa_reg[i][k]) - CW'(cxb_reg[i][k]);
            end
            qp_reg[k] <= e_reg[1][k] * e_reg[0][k];
            rp_reg[k] <= vp_reg[0][k] * e_reg[0][k];
        end
        for (int i = 0; i < 3; i++)
        begin
            dv_reg[i] <= SW'(sqv_reg[i][0]) + SW'(sqv_reg[i][1]) + SW'(sqv_reg[i][2]);
            de_reg[i] <= SW'(sqe_reg[i][0]) + SW'(sqe_reg[i][1]) + SW'(sqe_reg[i][2]);
            dwe_reg[i] <= SW'(we_reg[i][0]) + SW'(we_reg[i][1]) + SW'(we_reg[i][2]);
        end
        q_reg <= SW'(qp_reg[0]) + SW'(qp_reg[1]) + SW'(qp_reg[2]);
        r_reg <= SW'(rp_reg[0]) + SW'(rp_reg[1]) + SW'(rp_reg[2]);
    end

    logic signed [L2W-1:0] el2_s;
    logic signed [XSW-1:0] xsq [3][3];
    logic signed [LEW-1:0] lee [3];
    logic signed [MW-1:0]  den_a;
    logic signed [MW-1:0]  den_b;
    logic signed [MW-1:0]  m1;
    logic signed [MW-1:0]  m2;
    logic signed [MW-1:0]  m3;
    logic signed [MW-1:0]  m4;

    assign el2_s = $signed({1'b0, el2_reg});

    for (genvar j = 0; j < 3; j++)
    begin : g_edge
        for (genvar k = 0; k < 3; k++)
        begin : g_axis
            ptc_mul #(.A_W(CW), .B_W(CW)) u_xsq
            (
                .clk (clk),
                .a   (cc_reg[j][k]),
                .b   (cc_reg[j][k]),
                .p   (xsq[j][k])
            );
        end
        ptc_mul #(.A_W(L2W), .B_W(SW)) u_lee
        (
            .clk (clk),
            .a   (el2_s),
            .b   (de_reg[j]),
            .p   (lee[j])
        );
    end

    ptc_mul #(.A_W(SW), .B_W(SW)) u_den_a (.clk(clk), .a(de_reg[1]), .b(de_reg[0]), .p(den_a));
    ptc_mul #(.A_W(SW), .B_W(SW)) u_den_b (.clk(clk), .a(q_reg), .b(q_reg), .p(den_b));
    ptc_mul #(.A_W(SW), .B_W(SW)) u_m1 (.clk(clk), .a(dwe_reg[1]), .b(de_reg[0]), .p(m1));
    ptc_mul #(.A_W(SW), .B_W(SW)) u_m2 (.clk(clk), .a(r_reg), .b(q_reg), .p(m2));
    ptc_mul #(.A_W(SW), .B_W(SW)) u_m3 (.clk(clk), .a(r_reg), .b(de_reg[1]), .p(m3));
    ptc_mul #(.A_W(SW), .B_W(SW)) u_m4 (.clk(clk), .a(dwe_reg[1]), .b(q_reg), .p(m4));

    logic [2:0] nearv_s5_reg;
    logic [2:0] nearv_s6_reg;
    logic [2:0] nearv_s7_reg;
    logic [2:0] nearv_s8_reg;
    logic [2:0] oke_s5_reg;
    logic [2:0] oke_s6_reg;
    logic [2:0] oke_s7_reg;
    logic [2:0] neare_s8_reg;
    logic       inside_s8_reg;
    logic signed [XW-1:0]  xs_reg [3];
    logic signed [LEW-1:0] lee_reg [3];
    logic signed [DNW-1:0] den_reg;
    logic signed [DNW-1:0] n1_reg;
    logic signed [DNW-1:0] n2_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            nearv_s5_reg[i] <= VCW'(dv_reg[i]) < VCW'($signed({1'b0, vl2_reg}));
            oke_s5_reg[i] <= (de_reg[i] != '0) && !dwe_reg[i][SW-1] && (dwe_reg[i] != '0)
                             && (dwe_reg[i] < de_reg[i]);
            xs_reg[i] <= XW'(xsq[i][0]) + XW'(xsq[i][1]) + XW'(xsq[i][2]);
            lee_reg[i] <= lee[i];
            neare_s8_reg[i] <= oke_s7_reg[i] && (EW'(xs_reg[i]) < EW'(lee_reg[i]));
        end
        nearv_s6_reg <= nearv_s5_reg;
        nearv_s7_reg <= nearv_s6_reg;
        nearv_s8_reg <= nearv_s7_reg;
        oke_s6_reg <= oke_s5_reg;
        oke_s7_reg <= oke_s6_reg;
        den_reg <= DNW'(den_a) - DNW'(den_b);
        n1_reg <= DNW'(m1) - DNW'(m2);
        n2_reg <= DNW'(m4) - DNW'(m3);
        inside_s8_reg <= (den_reg != '0)
                         && !n1_reg[DNW-1] && (n1_reg != '0)
                         && !n2_reg[DNW-1] && (n2_reg != '0)
                         && ((NSW'(n1_reg) + NSW'(n2_reg)) < NSW'(den_reg));
    end

    ptc_pkg::relation_t relation_kind_reg;
    logic [1:0]         element_index_reg;

    always_ff @(posedge clk)
    begin
        priority if (nearv_s8_reg[0])
        begin
            relation_kind_reg <= ptc_pkg::REL_VERTEX;
            element_index_reg <= ptc_pkg::ELEM_FIRST;
        end
        else if (nearv_s8_reg[1])
        begin
            relation_kind_reg <= ptc_pkg::REL_VERTEX;
            element_index_reg <= ptc_pkg::ELEM_SECOND;
        end
        else if (nearv_s8_reg[2])
        begin
            relation_kind_reg <= ptc_pkg::REL_VERTEX;
            element_index_reg <= ptc_pkg::ELEM_THIRD;
        end
        else if (neare_s8_reg[0])
        begin
            relation_kind_reg <= ptc_pkg::REL_EDGE;
            element_index_reg <= ptc_pkg::ELEM_FIRST;
        end
        else if (neare_s8_reg[1])
        begin
            relation_kind_reg <= ptc_pkg::REL_EDGE;
            element_index_reg <= ptc_pkg::ELEM_SECOND;
        end
        else if (neare_s8_reg[2])
        begin
            relation_kind_reg <= ptc_pkg::REL_EDGE;
            element_index_reg <= ptc_pkg::ELEM_THIRD;
        end
        else if (inside_s8_reg)
        begin
            relation_kind_reg <= ptc_pkg::REL_INTERIOR;
            element_index_reg <= ptc_pkg::ELEM_FIRST;
        end
        else
        begin
            relation_kind_reg <= ptc_pkg::REL_EXTERIOR;
            element_index_reg <= ptc_pkg::ELEM_FIRST;
        end
    end

    assign result_valid = vld_reg[STAGES-1];
    assign relation_kind = relation_kind_reg;
    assign element_index = element_index_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##9 result_valid)
        else $error("An accepted transaction did not produce its result on time.");

    a_plain_index: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (relation_kind == ptc_pkg::REL_INTERIOR
                         || relation_kind == ptc_pkg::REL_EXTERIOR)
        |-> element_index == ptc_pkg::ELEM_FIRST)
        else $error("Interior or exterior result carries a nonzero element index.");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (element_index == ptc_pkg::ELEM_FIRST
                          || element_index == ptc_pkg::ELEM_SECOND
                          || element_index == ptc_pkg::ELEM_THIRD))
        else $error("Element index out of range.");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == ptc_pkg::REG_VERTEX_SNAP)
        |=> vertex_snap_reg == $past(pwdata[LB-1:0]))
        else $error("Vertex snap limit write was not taken.");

endmodule

// ===== design/ptc_mul.sv =====
// Two-stage pipelined signed multiplier built from four half-width partial products.
module ptc_mul #(
    parameter int A_W = 34,
    parameter int B_W = 34
) (
    input  logic                       clk,
    input  logic signed [A_W-1:0]      a,
    input  logic signed [B_W-1:0]      b,
    output logic signed [A_W+B_W-1:0]  p
);

    localparam int AL = A_W / 2;
    localparam int AH = A_W - AL;
    localparam int BL = B_W / 2;
    localparam int BH = B_W - BL;
    localparam int P_W = A_W + B_W;

    logic signed [AL:0]         al;
    logic signed [AH-1:0]       ah;
    logic signed [BL:0]         bl;
    logic signed [BH-1:0]       bh;
    logic signed [AL+BL+1:0]    ll_reg;
    logic signed [AL+BH:0]      lh_reg;
    logic signed [AH+BL:0]      hl_reg;
    logic signed [AH+BH-1:0]    hh_reg;
    logic signed [P_W-1:0]      p_reg;

    assign al = $signed({1'b0, a[AL-1:0]});
    assign ah = a[A_W-1:AL];
    assign bl = $signed({1'b0, b[BL-1:0]});
    assign bh = b[B_W-1:BL];

    always_ff @(posedge clk)
    begin
        ll_reg <= al * bl;
        lh_reg <= al * bh;
        hl_reg <= ah * bl;
        hh_reg <= ah * bh;
        p_reg <= (P_W'(hh_reg) <<< (AL + BL)) + (P_W'(hl_reg) <<< AL)
               + (P_W'(lh_reg) <<< BL) + P_W'(ll_reg);
    end

    assign p = p_reg;

endmodule

// ===== dv/point_triangle_classify_tb.sv =====
// Self-checking testbench for the point-triangle classifier.
module point_triangle_classify_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = ptc_pkg::COORD_BITS_DEF;
    localparam int LATENCY = 9;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [CB-1:0] coord_t;
    typedef coord_t vec_t [3];
    typedef logic signed [255:0] wide_t;

    typedef struct packed
    {
        ptc_pkg::relation_t kind;
        logic [1:0] elem;
    } relation_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ptc_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [ptc_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [ptc_pkg::APB_DATA_BITS-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    coord_t point_x = '0, point_y = '0, point_z = '0;
    coord_t corner_a_x = '0, corner_a_y = '0, corner_a_z = '0;
    coord_t corner_b_x = '0, corner_b_y = '0, corner_b_z = '0;
    coord_t corner_c_x = '0, corner_c_y = '0, corner_c_z = '0;
    logic result_valid;
    logic [1:0] relation_kind;
    logic [1:0] element_index;

    relation_rec_t expected_relations[$];
    logic [ptc_pkg::LIMIT_BITS-1:0] vertex_limit = 24'd17;
    logic [ptc_pkg::LIMIT_BITS-1:0] edge_limit = 24'd17;
    int fail_count = 0;
    longint cycle_count = 0;
    bit allow_idle = 1'b1;

    point_triangle_classify dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("point_triangle_classify_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_relations.size() == 0)
            begin
                $error("unexpected transaction: kind %0d elem %0d", relation_kind,
                       element_index);
                fail_count++;
            end
            else
            begin
                relation_rec_t e;
                e = expected_relations.pop_front();
                if (relation_kind !== e.kind)
                begin
                    $error("relation_kind: expected %0d actual %0d", e.kind, relation_kind);
                    fail_count++;
                end
                if (element_index !== e.elem)
                begin
                    $error("element_index: expected %0d actual %0d", e.elem, element_index);
                    fail_count++;
                end
            end
        end
    end

    function automatic wide_t dot3(wide_t a0, wide_t a1, wide_t a2,
                                   wide_t b0, wide_t b1, wide_t b2);
        return a0 * b0 + a1 * b1 + a2 * b2;
    endfunction

    function automatic bit near_corner(vec_t v, vec_t p, wide_t lim2);
        wide_t d[3];
        for (int k = 0; k < 3; k++) d[k] = wide_t'(v[k]) - wide_t'(p[k]);
        return dot3(d[0], d[1], d[2], d[0], d[1], d[2]) < lim2;
    endfunction

    function automatic bit near_side(vec_t s, vec_t t, vec_t p, wide_t lim2);
        wide_t e[3], w[3], ee, we, cr, acc;
        for (int k = 0; k < 3; k++)
        begin
            e[k] = wide_t'(t[k]) - wide_t'(s[k]);
            w[k] = wide_t'(p[k]) - wide_t'(s[k]);
        end
        ee = dot3(e[0], e[1], e[2], e[0], e[1], e[2]);
        if (ee == 0) return 1'b0;
        we = dot3(w[0], w[1], w[2], e[0], e[1], e[2]);
        if (!(we > 0 && we < ee)) return 1'b0;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            cr = e[(k + 1) % 3] * w[(k + 2) % 3] - e[(k + 2) % 3] * w[(k + 1) % 3];
            acc = acc + cr * cr;
        end
        return acc < lim2 * ee;
    endfunction

    function automatic relation_rec_t classify(vec_t p, vec_t a, vec_t b, vec_t c);
        vec_t corners[3];
        wide_t vl2, el2, e1[3], e2[3], v[3], d11, d22, d12, v1, v2, den, n1, n2;
        relation_rec_t r;
        corners[0] = a;
        corners[1] = b;
        corners[2] = c;
        vl2 = wide_t'(vertex_limit) * wide_t'(vertex_limit);
        el2 = wide_t'(edge_limit) * wide_t'(edge_limit);
        for (int i = 0; i < 3; i++)
            if (near_corner(corners[i], p, vl2))
            begin
                r.kind = ptc_pkg::REL_VERTEX;
                r.elem = 2'(i);
                return r;
            end
        for (int i = 0; i < 3; i++)
            if (near_side(corners[(i + 2) % 3], corners[i], p, el2))
            begin
                r.kind = ptc_pkg::REL_EDGE;
                r.elem = 2'(i);
                return r;
            end
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = wide_t'(b[k]) - wide_t'(a[k]);
            e2[k] = wide_t'(c[k]) - wide_t'(a[k]);
            v[k] = wide_t'(p[k]) - wide_t'(a[k]);
        end
        d11 = dot3(e1[0], e1[1], e1[2], e1[0], e1[1], e1[2]);
        d22 = dot3(e2[0], e2[1], e2[2], e2[0], e2[1], e2[2]);
        d12 = dot3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2]);
        v1 = dot3(v[0], v[1], v[2], e1[0], e1[1], e1[2]);
        v2 = dot3(v[0], v[1], v[2], e2[0], e2[1], e2[2]);
        den = d11 * d22 - d12 * d12;
        n1 = v1 * d22 - v2 * d12;
        n2 = v2 * d11 - v1 * d12;
        r.elem = ptc_pkg::ELEM_FIRST;
        r.kind = (den != 0 && n1 > 0 && n2 > 0 && n1 + n2 < den) ? ptc_pkg::REL_INTERIOR
                                                                   : ptc_pkg::REL_EXTERIOR;
        return r;
    endfunction

    task automatic idle_burst();
        if (allow_idle && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
        end
    endtask

    task automatic send_query(vec_t p, vec_t a, vec_t b, vec_t c);
        relation_rec_t rec;
        idle_burst();
        start <= 1'b1;
        point_x <= p[0]; point_y <= p[1]; point_z <= p[2];
        corner_a_x <= a[0]; corner_a_y <= a[1]; corner_a_z <= a[2];
        corner_b_x <= b[0]; corner_b_y <= b[1]; corner_b_z <= b[2];
        corner_c_x <= c[0]; corner_c_y <= c[1]; corner_c_z <= c[2];
        do @(posedge clk); while (busy);
        rec = classify(p, a, b, c);
        expected_relations.insert(expected_relations.size(), rec);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_relations.size() != 0) @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_limit(ptc_pkg::reg_index_t idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ptc_pkg::APB_ADDR_BITS'(4 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == ptc_pkg::REG_VERTEX_SNAP) vertex_limit = value[ptc_pkg::LIMIT_BITS-1:0];
        else edge_limit = value[ptc_pkg::LIMIT_BITS-1:0];
        repeat (3) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(2000)) - 1000);
            default: return coord_t'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic send_random(int mode);
        vec_t p, a, b, c;
        int pick;
        int s;
        for (int k = 0; k < 3; k++)
        begin
            a[k] = rand_coord(mode);
            b[k] = rand_coord(mode);
            c[k] = rand_coord(mode);
        end
        pick = $urandom_range(7);
        s = (mode == 0) ? 0 : ((mode == 1) ? 8 : 64);
        for (int k = 0; k < 3; k++)
        begin
            case (pick)
                0: p[k] = a[k] + coord_t'($signed($urandom_range(2 * s)) - s);
                1: p[k] = b[k] + coord_t'($signed($urandom_range(2 * s)) - s);
                2: p[k] = c[k] + coord_t'($signed($urandom_range(2 * s)) - s);
                3: p[k] = coord_t'((64'(a[k]) + 64'(b[k])) >>> 1)
                          + coord_t'($signed($urandom_range(2 * s)) - s);
                4: p[k] = coord_t'((64'(a[k]) + 64'(c[k]) + 64'(b[k])) / 3);
                5: p[k] = coord_t'((64'(b[k]) + 64'(c[k])) >>> 1);
                default: p[k] = rand_coord(mode);
            endcase
        end
        if ($urandom_range(15) == 0) c = b;
        send_query(p, a, b, c);
    endtask

    task automatic test_directed();
        vec_t z, mx, mn, a, b, c, p;
        z = '{0, 0, 0};
        mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        a = '{0, 0, 0};
        b = '{1000, 0, 0};
        c = '{0, 1000, 0};
        send_query(z, z, z, z);
        send_query(mx, mn, mx, mn);
        send_query(mn, mx, mn, mx);
        send_query(mx, mn, '{32'sh7fffffff, 32'sh80000000, 0}, '{0, 0, 32'sh7fffffff});
        send_query('{5, 5, 0}, a, b, c);
        send_query('{1003, 2, 0}, a, b, c);
        send_query('{1, 1003, 1}, a, b, c);
        send_query('{500, 3, 0}, a, b, c);
        send_query('{3, 500, 0}, a, b, c);
        send_query('{500, 497, 0}, a, b, c);
        send_query('{200, 200, 0}, a, b, c);
        send_query('{200, 200, 50}, a, b, c);
        send_query('{900, 900, 0}, a, b, c);
        send_query('{-100, 50, 0}, a, b, c);
        send_query('{500, 500, 0}, a, b, '{2000, 0, 0});
        send_query('{500, 0, 0}, a, b, b);
        send_query('{500, 0, 0}, a, a, a);
        p = '{-2000, 0, 0};
        send_query(p, a, b, '{3000, 0, 0});
        drain();
    endtask

    task automatic test_limits();
        logic [31:0] settings[6] = '{32'h0, 32'h00ffffff, 32'hff000040, 32'd17, 32'd300,
                                     32'hffffffff};
        for (int i = 0; i < 6; i++)
        begin
            write_limit(ptc_pkg::REG_VERTEX_SNAP, settings[i]);
            write_limit(ptc_pkg::REG_EDGE_SNAP, settings[(i + 2) % 6]);
            repeat (40) send_random(i % 3);
            drain();
        end
        write_limit(ptc_pkg::REG_VERTEX_SNAP, 32'd17);
        write_limit(ptc_pkg::REG_EDGE_SNAP, 32'd17);
    endtask

    task automatic test_random();
        for (int i = 0; i < 1390; i++)
        begin
            if (i == 1150) allow_idle = 1'b0;
            if (i == 600) drain();
            send_random($urandom_range(2));
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_limits();
        test_random();
        if (fail_count == 0 && expected_relations.size() == 0)
            $display("point_triangle_classify_tb passed");
        else
            $display("point_triangle_classify_tb failed");
        $finish;
    end
endmodule

// ===== files.f =====
design/ptc_pkg.sv
design/ptc_mul.sv
design/point_triangle_classify.sv
dv/point_triangle_classify_tb.sv
